FILE: rtl/tbffd_pkg.sv
// Shared types and constants of the trivariate Bezier FFD evaluator.
package tbffd_pkg;

  localparam int CONTROL_POINTS = 27;
  localparam int IDX_W          = 5;
  localparam int STRIDE_K       = 3;
  localparam int STRIDE_J       = 9;
  localparam int LAST_TAP       = 2;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_EVAL  = 2'd1;
  localparam logic [1:0] OP_NEAR  = 2'd2;

  localparam logic KIND_POS  = 1'b0;
  localparam logic KIND_NEAR = 1'b1;

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_CENTER_Z = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WGT,
    ST_RUN,
    ST_WAIT
  } st_t;

endpackage

FILE: rtl/tbffd_blend_cell.sv
// One three-tap Bernstein blend cell; a chain of three forms the tensor evaluation.
module tbffd_blend_cell import tbffd_pkg::*; #(
  parameter int COORD_BITS      = 24,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [2:0][PARAM_FRAC_BITS:0]        w,
  input  logic                                 in_vld,
  input  logic signed [COORD_BITS-1:0]         in_val,
  output logic                                 out_vld,
  output logic signed [COORD_BITS-1:0]         out_val
);

  localparam int PW    = PARAM_FRAC_BITS + 1;
  localparam int ACC_W = COORD_BITS + PARAM_FRAC_BITS + 2;
  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'((1 << PARAM_FRAC_BITS) - 1);

  logic [1:0]               tap_r, tap_nxt;
  logic [PW-1:0]            wsel;
  logic signed [ACC_W-1:0]  prod_r;
  logic                     p_vld_r, p_first_r, p_last_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     done_r;
  logic [ACC_W-1:0]         biased;
  logic                     out_vld_r;
  logic signed [COORD_BITS-1:0] out_val_r;

  always_comb begin
    case (tap_r)
      2'd0:    wsel = w[0];
      2'd1:    wsel = w[1];
      default: wsel = w[2];
    endcase
    tap_nxt = (tap_r == 2'(LAST_TAP)) ? 2'd0 : tap_r + 2'd1;
    // round toward zero: bias negative sums before the shift
    biased = acc_r[ACC_W-1] ? (acc_r + ROUND_BIAS) : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r     <= 2'd0;
      p_vld_r   <= 1'b0;
      done_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_vld) tap_r <= tap_nxt;
      p_vld_r   <= in_vld;
      done_r    <= p_vld_r & p_last_r;
      out_vld_r <= done_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= ACC_W'($signed({1'b0, wsel}) * in_val);
    p_first_r <= (tap_r == 2'd0);
    p_last_r  <= (tap_r == 2'(LAST_TAP));
    if (p_vld_r) acc_r <= (p_first_r ? '0 : acc_r) + prod_r;
    out_val_r <= biased[PARAM_FRAC_BITS +: COORD_BITS];
  end

  assign out_vld = out_vld_r;
  assign out_val = out_val_r;

endmodule

FILE: rtl/tbffd_near_unit.sv
// Squared-distance pipeline with a running minimum over the streamed control net.
module tbffd_near_unit import tbffd_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic [3*COORD_BITS-1:0] in_pt,
  input  logic [3*COORD_BITS-1:0] rel,
  output logic                    out_vld,
  output logic [IDX_W-1:0]        out_idx
);

  localparam int DW = COORD_BITS + 1;
  localparam int SW = 2 * DW;
  localparam int TW = SW + 2;

  logic signed [DW-1:0] d_r [3];
  logic [SW-1:0]        sq_r [3];
  logic [TW-1:0]        dist_r, best_r;
  logic                 v1_r, v2_r, v3_r;
  logic [IDX_W-1:0]     n_r, best_idx_r, out_idx_r;
  logic                 out_vld_r;
  logic                 take;

  for (genvar c = 0; c < 3; c++) begin : g_axis
    logic signed [COORD_BITS-1:0] rc, pc;
    assign rc = rel[c*COORD_BITS +: COORD_BITS];
    assign pc = in_pt[c*COORD_BITS +: COORD_BITS];
    always_ff @(posedge clk) begin
      d_r[c]  <= DW'(rc) - DW'(pc);
      sq_r[c] <= SW'(d_r[c] * d_r[c]);
    end
  end

  assign take = (n_r == '0) || (dist_r < best_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      n_r       <= '0;
      out_vld_r <= 1'b0;
    end else begin
      v1_r      <= in_vld;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      out_vld_r <= v3_r && (n_r == IDX_W'(CONTROL_POINTS - 1));
      if (v3_r) n_r <= (n_r == IDX_W'(CONTROL_POINTS - 1)) ? '0 : n_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= TW'(sq_r[0]) + TW'(sq_r[1]) + TW'(sq_r[2]);
    if (v3_r && take) begin
      best_r     <= dist_r;
      best_idx_r <= n_r;
    end
    out_idx_r <= take ? n_r : best_idx_r;
  end

  assign out_vld = out_vld_r;
  assign out_idx = out_idx_r;

endmodule

FILE: rtl/trivariate_bezier_ffd_eval_core.sv
// Top level of the trivariate quadratic Bezier FFD evaluator.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------------
//  in_      | in  | in_tvalid/tready   | tdata: point_index,x,y,z,s,t,u; tuser: opcode
//  out_     | out | out_tvalid/tready  | tdata: x,y,z,nearest_index; tuser: result_kind
//  cfg (APB)| in  | psel/penable       | center_x/y/z at byte addr 0, 4, 8
//
// A write request is stored when it is accepted. An evaluate request goes from acceptance
// to a valid result and to the next accept through the weight state, 27 memory reads (one
// control point per cycle from the single read port), the read register, three blend
// cells, then the pending and output registers. A nearest request uses the same
// reads, then the distance pipe of difference, square, sum and minimum registers.
// Synchronous active-low reset clears control state; the control net is
// undefined until written. A finished result waits in a pending register and then
// the output register, so one stalled result does not block the next request.
module trivariate_bezier_ffd_eval_core import tbffd_pkg::*; #(
  parameter int COORD_BITS      = 24,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // in_tdata from bit 0: point_index, coord_x, coord_y, coord_z, param_s, param_t, param_u
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [((IDX_W+3*COORD_BITS+3*(PARAM_FRAC_BITS+1)+7)/8)*8-1:0] in_tdata,
  input  logic [1:0]           in_tuser,   // opcode
  // out_tdata from bit 0: out_x, out_y, out_z, nearest_index
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [((3*COORD_BITS+IDX_W+7)/8)*8-1:0] out_tdata,
  output logic [0:0]           out_tuser,  // result_kind
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int CB     = COORD_BITS;
  localparam int F      = PARAM_FRAC_BITS;
  localparam int PW     = F + 1;
  localparam int OUT_W  = ((3*CB + IDX_W + 7) / 8) * 8;
  localparam int OFS_X  = IDX_W;
  localparam int OFS_P  = IDX_W + 3*CB;
  localparam logic [PW-1:0] ONE = PW'(1) << F;

  // ---------------- configuration ----------------
  logic signed [CB-1:0] center_r [3];
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r[0] <= '0;
      center_r[1] <= '0;
      center_r[2] <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CENTER_X: center_r[0] <= pwdata[CB-1:0];
        REG_CENTER_Y: center_r[1] <= pwdata[CB-1:0];
        REG_CENTER_Z: center_r[2] <= pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CENTER_X: prdata = 32'(center_r[0]);
      REG_CENTER_Y: prdata = 32'(center_r[1]);
      REG_CENTER_Z: prdata = 32'(center_r[2]);
      default:      prdata = '0;
    endcase
  end

  // ---------------- request fields ----------------
  logic [IDX_W-1:0]     in_idx;
  logic [3*CB-1:0]      in_pt;
  logic [PW-1:0]        in_par [3];
  logic                 in_acc;

  assign in_idx = in_tdata[IDX_W-1:0];
  assign in_pt  = in_tdata[OFS_X +: 3*CB];
  for (genvar p = 0; p < 3; p++) begin : g_par
    assign in_par[p] = in_tdata[OFS_P + p*PW +: PW];
  end
  assign in_acc = in_tvalid & in_tready;

  // ---------------- control net memory ----------------
  logic [3*CB-1:0]  net_mem [CONTROL_POINTS];
  logic [3*CB-1:0]  rd_q_r;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == OP_WRITE && in_idx < IDX_W'(CONTROL_POINTS))
      net_mem[in_idx] <= in_pt;
    if (rd_en) rd_q_r <= net_mem[rd_addr];
  end

  // ---------------- sequencer ----------------
  st_t            state_r, state_nxt;
  logic [1:0]     op_r;
  logic [PW-1:0]  par_r [3];       // saturated s, t, u
  logic [3*CB-1:0] rel_r;          // query minus center, saturated
  logic [2:0][PW-1:0] w_r [3];     // weights per parameter
  logic [1:0]     ci_r, cj_r, ck_r;
  logic           last_rd;
  logic           done;
  logic           pend_r;

  assign last_rd = (ci_r == 2'(LAST_TAP)) && (cj_r == 2'(LAST_TAP)) &&
                   (ck_r == 2'(LAST_TAP));
  // evaluate walks i outer, j, then k inner; nearest walks the slots in order
  assign rd_addr = (op_r == OP_EVAL) ?
      (IDX_W'(ci_r) + IDX_W'(ck_r) * IDX_W'(STRIDE_K) + IDX_W'(cj_r) * IDX_W'(STRIDE_J)) :
      (IDX_W'(ci_r) * IDX_W'(STRIDE_J) + IDX_W'(cj_r) * IDX_W'(STRIDE_K) + IDX_W'(ck_r));

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    rd_en     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = ~pend_r;
        if (in_acc && (in_tuser == OP_EVAL || in_tuser == OP_NEAR)) state_nxt = ST_WGT;
      end
      ST_WGT: state_nxt = ST_RUN;
      ST_RUN: begin
        rd_en = 1'b1;
        if (last_rd) state_nxt = ST_WAIT;
      end
      ST_WAIT: if (done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_vld_r <= 1'b0;
      ci_r     <= '0;
      cj_r     <= '0;
      ck_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      if (rd_en) begin
        ck_r <= (ck_r == 2'(LAST_TAP)) ? 2'd0 : ck_r + 2'd1;
        if (ck_r == 2'(LAST_TAP)) begin
          cj_r <= (cj_r == 2'(LAST_TAP)) ? 2'd0 : cj_r + 2'd1;
          if (cj_r == 2'(LAST_TAP)) ci_r <= (ci_r == 2'(LAST_TAP)) ? 2'd0 : ci_r + 2'd1;
        end
      end
    end
  end

  // request capture: clamp parameters, offset and clamp the query
  logic signed [CB:0]   diff [3];
  logic [2*PW-1:0]      sq_n [3], sq_x [3];
  logic [PW-1:0]        nx [3], w0 [3], w2 [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c] = (CB+1)'(signed'(in_pt[c*CB +: CB])) - (CB+1)'(center_r[c]);
      nx[c]   = ONE - par_r[c];
      sq_n[c] = nx[c] * nx[c];
      sq_x[c] = par_r[c] * par_r[c];
      w0[c]   = sq_n[c][F +: PW];
      w2[c]   = sq_x[c][F +: PW];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int c = 0; c < 3; c++) begin
        par_r[c] <= (in_par[c] > ONE) ? ONE : in_par[c];
        if (diff[c][CB] != diff[c][CB-1])
          rel_r[c*CB +: CB] <= diff[c][CB] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
        else
          rel_r[c*CB +: CB] <= diff[c][CB-1:0];
      end
    end
    if (state_r == ST_WGT) begin
      for (int c = 0; c < 3; c++) begin
        w_r[c][0] <= w0[c];
        w_r[c][2] <= w2[c];
        w_r[c][1] <= ONE - w0[c] - w2[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) op_r <= in_tuser;
  end

  // ---------------- blend chains: u, then t, then s ----------------
  logic              ev_vld;
  logic              ch_vld [3][4];
  logic signed [CB-1:0] ch_val [3][4];

  assign ev_vld = rd_vld_r && (op_r == OP_EVAL);

  for (genvar c = 0; c < 3; c++) begin : g_chain
    assign ch_vld[c][0] = ev_vld;
    assign ch_val[c][0] = rd_q_r[c*CB +: CB];
    for (genvar s = 0; s < 3; s++) begin : g_cell
      // cell 0 blends over k with u weights, cell 1 over j with t, cell 2 over i with s
      tbffd_blend_cell #(
        .COORD_BITS      (COORD_BITS),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .w       (w_r[2-s]),
        .in_vld  (ch_vld[c][s]),
        .in_val  (ch_val[c][s]),
        .out_vld (ch_vld[c][s+1]),
        .out_val (ch_val[c][s+1])
      );
    end
  end

  // ---------------- nearest search ----------------
  logic             nr_vld;
  logic [IDX_W-1:0] nr_idx;

  tbffd_near_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_near (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (rd_vld_r && (op_r == OP_NEAR)),
    .in_pt   (rd_q_r),
    .rel     (rel_r),
    .out_vld (nr_vld),
    .out_idx (nr_idx)
  );

  // ---------------- result path: pending slot, then output register ----------------
  logic [OUT_W-1:0] pend_data_r, out_data_r;
  logic             pend_kind_r, out_kind_r;
  logic             out_vld_r;
  logic             out_free;

  assign done     = ch_vld[0][3] | nr_vld;
  assign out_free = ~out_vld_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (done) pend_r <= 1'b1;
      else if (pend_r && out_free) pend_r <= 1'b0;
      if (out_free) out_vld_r <= pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      if (nr_vld) begin
        pend_kind_r <= KIND_NEAR;
        pend_data_r <= OUT_W'({nr_idx, {(3*CB){1'b0}}});
      end else begin
        pend_kind_r <= KIND_POS;
        pend_data_r <= OUT_W'({{IDX_W{1'b0}}, ch_val[2][3], ch_val[1][3], ch_val[0][3]});
      end
    end
    if (out_free && pend_r) begin
      out_kind_r <= pend_kind_r;
      out_data_r <= pend_data_r;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_kind_r;

endmodule

FILE: dv/tb_top.sv
// Self-checking bench for the trivariate Bezier FFD evaluator core.
module tb_top;
  import tbffd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 24;
  localparam int FB = 16;
  localparam int PW = FB + 1;
  localparam int IN_W = ((IDX_W + 3*CB + 3*PW + 7)/8)*8;
  localparam int OUT_W = ((3*CB + IDX_W + 7)/8)*8;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam longint CMAX = (64'sd1 <<< (CB-1)) - 1;
  localparam longint CMIN = -(64'sd1 <<< (CB-1));
  localparam int STALL_LIMIT = 20000;
  localparam logic [1:0] OP_SPARE = 2'd3;   // unused opcode, ignored by the core

  typedef struct {
    logic [1:0] op;
    logic [IDX_W-1:0] slot;
    logic [CB-1:0] x, y, z;
    logic [PW-1:0] s, t, u;
  } req_t;

  typedef struct {
    logic kind;
    logic [CB-1:0] x, y, z;
    logic [IDX_W-1:0] idx;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid, out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;

  trivariate_bezier_ffd_eval_core #(.COORD_BITS(CB), .PARAM_FRAC_BITS(FB)) u_top (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready);

  always #5 clk = ~clk;

  // predictor state: control net and body center
  longint net[CONTROL_POINTS][3];
  longint ctr[3];

  req_t pending_reqs[$];
  res_t expected_res[$];
  int errors = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_off = 0;
  int quiet_cycles = 0;

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic void enqueue_req(req_t r);
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic longint sat(longint v);
    return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
  endfunction

  function automatic void bern(logic [PW-1:0] raw, output longint w[3]);
    longint p = raw;
    longint q;
    if (p > ONE) p = ONE;
    q = ONE - p;
    w[0] = (q * q) >>> FB;
    w[2] = (p * p) >>> FB;
    w[1] = ONE - w[0] - w[2];
  endfunction

  // SV '/' on signed longint truncates toward zero
  function automatic longint mix(longint w[3], longint a, longint b, longint c);
    return (w[0]*a + w[1]*b + w[2]*c) / ONE;
  endfunction

  // update state and queue the result, if any, for one accepted request
  function automatic void predict_deform(req_t r);
    longint q[3], ws[3], wt[3], wu[3], ps[3], pt[3], rel[3];
    longint d;
    logic [127:0] sq_sum, best;
    res_t e;
    q[0] = longint'(signed'(r.x)); q[1] = longint'(signed'(r.y));
    q[2] = longint'(signed'(r.z));
    e = '{kind: KIND_POS, x: '0, y: '0, z: '0, idx: '0};
    case (r.op)
      OP_WRITE: begin
        if (r.slot < CONTROL_POINTS) begin
          for (int c = 0; c < 3; c++) net[r.slot][c] = q[c];
        end
      end
      OP_EVAL: begin
        bern(r.s, ws); bern(r.t, wt); bern(r.u, wu);
        for (int c = 0; c < 3; c++) begin
          for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++)
              pt[j] = mix(wu, net[i+STRIDE_J*j][c], net[i+STRIDE_K+STRIDE_J*j][c],
                          net[i+2*STRIDE_K+STRIDE_J*j][c]);
            ps[i] = mix(wt, pt[0], pt[1], pt[2]);
          end
          d = sat(mix(ws, ps[0], ps[1], ps[2]));
          if (c == 0) e.x = d[CB-1:0];
          else if (c == 1) e.y = d[CB-1:0];
          else e.z = d[CB-1:0];
        end
        expected_res = {expected_res, e};
      end
      OP_NEAR: begin
        e.kind = KIND_NEAR;
        for (int c = 0; c < 3; c++) rel[c] = sat(q[c] - ctr[c]);
        best = '1;
        for (int n = 0; n < CONTROL_POINTS; n++) begin
          sq_sum = '0;
          for (int c = 0; c < 3; c++) begin
            d = rel[c] - net[n][c];
            sq_sum += 128'(d * d);
          end
          if (n == 0 || sq_sum < best) begin
            best = sq_sum;
            e.idx = n[IDX_W-1:0];
          end
        end
        expected_res = {expected_res, e};
      end
      default: ;
    endcase
  endfunction

  // input driver: requests from pending_reqs, random idle
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_t r;
          r = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= r.op;
          in_tdata <= IN_W'({r.u, r.t, r.s, r.z, r.y, r.x, r.slot});
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // track accepted requests on the input side
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      req_t r;
      {r.u, r.t, r.s, r.z, r.y, r.x, r.slot} = in_tdata[IDX_W+3*CB+3*PW-1:0];
      r.op = in_tuser;
      predict_deform(r);
    end
  end

  // result monitor and backpressure
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        res_t e;
        if (expected_res.size() == 0) begin
          report("unexpected result", out_tuser, -1);
        end else begin
          e = expected_res.pop_front();
          if (out_tuser[0] !== e.kind) report("result_kind", out_tuser, e.kind);
          if (out_tdata[CB-1:0] !== e.x) report("out_x", out_tdata[CB-1:0], e.x);
          if (out_tdata[2*CB-1:CB] !== e.y) report("out_y", out_tdata[2*CB-1:CB], e.y);
          if (out_tdata[3*CB-1:2*CB] !== e.z) report("out_z", out_tdata[3*CB-1:2*CB], e.z);
          if (out_tdata[3*CB+IDX_W-1:3*CB] !== e.idx)
            report("nearest_index", out_tdata[3*CB+IDX_W-1:3*CB], e.idx);
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: no request or result moving for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] regidx, longint val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {regidx, 2'b00}; pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    ctr[regidx] = sat(longint'(signed'(val[CB-1:0])));
  endtask

  function automatic logic [CB-1:0] rnd_coord();
    case ($urandom_range(5))
      0: return CB'(CMAX);
      1: return CB'(CMIN);
      2: return CB'($urandom_range(2000) - 1000);
      default: return CB'($urandom);
    endcase
  endfunction

  function automatic logic [PW-1:0] rnd_param();
    case ($urandom_range(7))
      0: return '0;
      1: return PW'(ONE);
      2: return PW'($urandom_range(2**PW-1));   // above one too
      default: return PW'($urandom_range(ONE));
    endcase
  endfunction

  function automatic req_t mk(logic [1:0] op, int slot = 0);
    req_t r;
    r.op = op; r.slot = IDX_W'(slot);
    r.x = rnd_coord(); r.y = rnd_coord(); r.z = rnd_coord();
    r.s = rnd_param(); r.t = rnd_param(); r.u = rnd_param();
    return r;
  endfunction

  // wait until every expected result is in, then let the pipe drain
  task automatic drain();
    wait (pending_reqs.size() == 0 && !in_tvalid && expected_res.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    req_t r;
    ctr = '{0, 0, 0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fill the whole net, extremes of coordinates
    for (int n = 0; n < CONTROL_POINTS; n++) begin
      r = mk(OP_WRITE, n);
      if (n == 0) begin r.x = CB'(CMAX); r.y = CB'(CMAX); r.z = CB'(CMAX); end
      if (n == 26) begin r.x = CB'(CMIN); r.y = CB'(CMIN); r.z = CB'(CMIN); end
      enqueue_req(r);
    end
    r = mk(OP_WRITE, 31); enqueue_req(r);          // slot out of range
    r = mk(OP_EVAL); r.s = '0; r.t = '0; r.u = '0; enqueue_req(r);
    r = mk(OP_EVAL); r.s = '1; r.t = '1; r.u = '1; enqueue_req(r);
    r = mk(OP_EVAL); r.s = PW'(ONE/2); r.t = PW'(ONE); r.u = '0;
    enqueue_req(r);
    r = mk(OP_NEAR); r.x = CB'(CMAX); r.y = CB'(CMIN); r.z = '0; enqueue_req(r);
    r = mk(OP_NEAR); enqueue_req(r);
    r = mk(OP_SPARE); enqueue_req(r);
    drain();

    // several center settings, extremes included, with random traffic
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin cfg_write(REG_CENTER_X, CMAX); cfg_write(REG_CENTER_Y, CMIN);
                 cfg_write(REG_CENTER_Z, 0); end
        1: begin cfg_write(REG_CENTER_X, CMIN); cfg_write(REG_CENTER_Y, CMAX);
                 cfg_write(REG_CENTER_Z, CMAX); end
        2: cfg_write(REG_CENTER_Z, CMIN);
        default: begin cfg_write(REG_CENTER_X, rnd_coord());
                 cfg_write(REG_CENTER_Y, rnd_coord()); cfg_write(REG_CENTER_Z, rnd_coord()); end
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 72; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 72; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      if (ph == 0) hold_off = 600;   // long receiver hold-off fills the block
      for (int n = 0; n < 180; n++) begin
        int pick;
        int k;
        pick = $urandom_range(99);
        if (pick < 30) r = mk(OP_WRITE, $urandom_range(26));
        else if (pick < 32) r = mk(OP_WRITE, $urandom_range(31));
        else if (pick < 33) r = mk(OP_SPARE);
        else if (pick < 65) r = mk(OP_EVAL);
        else begin
          r = mk(OP_NEAR);
          if ($urandom_range(1)) begin   // query near a stored point for close calls
            k = $urandom_range(26);
            r.x = CB'(net[k][0] + ctr[0] + $urandom_range(4) - 2);
            r.y = CB'(net[k][1] + ctr[1]);
            r.z = CB'(net[k][2] + ctr[2]);
          end
        end
        enqueue_req(r);
      end
      drain();
    end

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
